// ----- design/dsseq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsseq_pkg
// Types, register indexes, codes and half-step phase tables shared by the
// dual stepper sequencer.
// ----------------------------------------------------------------------------
package dsseq_pkg;

    // Shortest step period in ticks; smaller programmed periods are raised to it
    localparam logic [15:0] MIN_PERIOD = 16'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MOTOR_ENABLE = 3'd0;
    localparam logic [2:0] REG_DIR_ZERO     = 3'd1;
    localparam logic [2:0] REG_DIR_ONE      = 3'd2;
    localparam logic [2:0] REG_REVOLUTIONS  = 3'd3;
    localparam logic [2:0] REG_STEP_PERIOD  = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Input action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // Direction codes
    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    // End-of-travel codes
    typedef logic [1:0] t_end;
    localparam t_end END_NONE = 2'd0;
    localparam t_end END_CW   = 2'd1;
    localparam t_end END_CCW  = 2'd2;

    // Coil drive, bit3 A .. bit0 D
    typedef logic [3:0] t_coils;
    localparam t_coils COILS_OFF = 4'h0;

    typedef struct packed {
        logic action;
        logic limit_cw_zero;
        logic limit_ccw_zero;
        logic limit_cw_one;
        logic limit_ccw_one;
    } t_in_item;

    typedef struct packed {
        t_coils coils_zero;
        t_coils coils_one;
        t_end   end_zero;
        t_end   end_one;
        logic   busy_res;
        logic   done_res;
        logic   bad_mask;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  motor_enable;
        logic        dir_zero;
        logic        dir_one;
        logic [15:0] revolutions;
        logic [15:0] step_period_ms;
    } t_cfg;

    // Half-step table entry for a direction and step index
    function automatic t_coils phase_lookup(input logic dir, input logic [2:0] idx);
        t_coils cw;
        t_coils ccw;
        case (idx)
            3'd0: begin cw = 4'h9; ccw = 4'h8; end
            3'd1: begin cw = 4'h1; ccw = 4'hC; end
            3'd2: begin cw = 4'h3; ccw = 4'h4; end
            3'd3: begin cw = 4'h2; ccw = 4'h6; end
            3'd4: begin cw = 4'h6; ccw = 4'h2; end
            3'd5: begin cw = 4'h4; ccw = 4'h3; end
            3'd6: begin cw = 4'hC; ccw = 4'h1; end
            3'd7: begin cw = 4'h8; ccw = 4'h9; end
            default: begin cw = COILS_OFF; ccw = COILS_OFF; end
        endcase
        return (dir == DIR_CCW) ? ccw : cw;
    endfunction

    // Active-low limit switch for the direction of travel
    function automatic t_end end_lookup(input logic dir, input logic lim_cw,
                                        input logic lim_ccw);
        if (dir == DIR_CW) begin
            return lim_cw ? END_NONE : END_CW;
        end
        return lim_ccw ? END_NONE : END_CCW;
    endfunction

endpackage

// ----- design/dsseq_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsseq_in_if
// Valid/ready channel carrying one sequencer input item.
// ----------------------------------------------------------------------------
interface dsseq_in_if import dsseq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/dsseq_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsseq_out_if
// Valid/ready channel carrying one sequencer result item.
// ----------------------------------------------------------------------------
interface dsseq_out_if import dsseq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/dsseq_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsseq_cfg
// Configuration register file, write-only, one register per index.
// ----------------------------------------------------------------------------
module dsseq_cfg import dsseq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MOTOR_ENABLE: r_cfg.motor_enable   <= i_cfg_data[7:0];
                REG_DIR_ZERO:     r_cfg.dir_zero       <= i_cfg_data[0];
                REG_DIR_ONE:      r_cfg.dir_one        <= i_cfg_data[0];
                REG_REVOLUTIONS:  r_cfg.revolutions    <= i_cfg_data;
                REG_STEP_PERIOD:  r_cfg.step_period_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/dsseq_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsseq_core
// Run state and step logic. On each fired item it computes the next state
// and the matching result in one pass.
// ----------------------------------------------------------------------------
module dsseq_core import dsseq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    logic        r_running, n_running;
    logic [2:0]  r_step_idx, n_step_idx;
    logic [15:0] r_rev_cnt, n_rev_cnt;
    logic [15:0] r_wait_cnt, n_wait_cnt;
    t_coils      r_coils0, n_coils0;
    t_coils      r_coils1, n_coils1;
    t_end        r_end0, n_end0;
    t_end        r_end1, n_end1;
    logic [1:0]  r_run_mask, n_run_mask;
    logic        r_run_dir0, n_run_dir0;
    logic        r_run_dir1, n_run_dir1;
    logic [15:0] r_run_period, n_run_period;

    logic        w_done;
    logic        w_bad;
    logic        w_step;
    logic [2:0]  w_idx;
    logic [1:0]  w_mask;
    logic        w_dir0;
    logic        w_dir1;
    logic [15:0] w_period;
    logic [15:0] w_clamped;
    logic [15:0] w_wait_dec;
    logic        w_stop;

    assign w_clamped = (i_cfg.step_period_ms < MIN_PERIOD) ? MIN_PERIOD
                                                          : i_cfg.step_period_ms;

    // Next-state logic
    always_comb begin
        n_running    = r_running;
        n_step_idx   = r_step_idx;
        n_rev_cnt    = r_rev_cnt;
        n_wait_cnt   = r_wait_cnt;
        n_coils0     = r_coils0;
        n_coils1     = r_coils1;
        n_end0       = r_end0;
        n_end1       = r_end1;
        n_run_mask   = r_run_mask;
        n_run_dir0   = r_run_dir0;
        n_run_dir1   = r_run_dir1;
        n_run_period = r_run_period;
        w_done       = 1'b0;
        w_bad        = 1'b0;
        w_step       = 1'b0;
        w_idx        = r_step_idx;
        w_mask       = r_run_mask;
        w_dir0       = r_run_dir0;
        w_dir1       = r_run_dir1;
        w_period     = r_run_period;
        w_wait_dec   = (r_wait_cnt != 16'd0) ? (r_wait_cnt - 16'd1) : 16'd0;
        w_stop       = 1'b0;

        if (i_item.action == ACT_START) begin
            // Start: ignored while a run is active
            if (!r_running) begin
                if (|i_cfg.motor_enable[7:2]) begin
                    w_bad = 1'b1;
                end else begin
                    n_run_mask   = i_cfg.motor_enable[1:0];
                    n_run_dir0   = i_cfg.dir_zero;
                    n_run_dir1   = i_cfg.dir_one;
                    n_run_period = w_clamped;
                    n_end0       = END_NONE;
                    n_end1       = END_NONE;
                    n_step_idx   = 3'd0;
                    n_rev_cnt    = i_cfg.revolutions;
                    if (i_cfg.revolutions == 16'd0) begin
                        n_coils0  = COILS_OFF;
                        n_coils1  = COILS_OFF;
                        n_running = 1'b0;
                        w_done    = 1'b1;
                    end else begin
                        n_running = 1'b1;
                        w_step    = 1'b1;
                        w_idx     = 3'd0;
                        w_mask    = i_cfg.motor_enable[1:0];
                        w_dir0    = i_cfg.dir_zero;
                        w_dir1    = i_cfg.dir_one;
                        w_period  = w_clamped;
                    end
                end
            end
        end else if (r_running) begin
            // Tick: count down, then advance one half step
            n_wait_cnt = w_wait_dec;
            if (w_wait_dec == 16'd0) begin
                w_idx      = r_step_idx + 3'd1;
                n_step_idx = w_idx;
                n_rev_cnt  = (w_idx == 3'd0) ? (r_rev_cnt - 16'd1) : r_rev_cnt;
                if (n_rev_cnt == 16'd0) begin
                    n_coils0  = COILS_OFF;
                    n_coils1  = COILS_OFF;
                    n_running = 1'b0;
                    w_done    = 1'b1;
                end else begin
                    w_step = 1'b1;
                end
            end
        end

        // Step: sample limits, drive phases, check for early stop
        if (w_step) begin
            if (w_mask[0]) begin
                n_end0 = end_lookup(w_dir0, i_item.limit_cw_zero, i_item.limit_ccw_zero);
                if (n_end0 == END_NONE) begin
                    n_coils0 = phase_lookup(w_dir0, w_idx);
                end
            end
            if (w_mask[1]) begin
                n_end1 = end_lookup(w_dir1, i_item.limit_cw_one, i_item.limit_ccw_one);
                if (n_end1 == END_NONE) begin
                    n_coils1 = phase_lookup(w_dir1, w_idx);
                end
            end
            w_stop = ((w_mask == 2'd1) && (n_end0 != END_NONE)) ||
                     ((w_mask == 2'd2) && (n_end1 != END_NONE)) ||
                     ((w_mask == 2'd3) && (n_end0 != END_NONE) && (n_end1 != END_NONE));
            if (w_stop) begin
                n_coils0  = COILS_OFF;
                n_coils1  = COILS_OFF;
                n_running = 1'b0;
                w_done    = 1'b1;
            end else begin
                n_wait_cnt = w_period;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_step_idx   <= 3'd0;
            r_rev_cnt    <= 16'd0;
            r_wait_cnt   <= 16'd0;
            r_coils0     <= COILS_OFF;
            r_coils1     <= COILS_OFF;
            r_end0       <= END_NONE;
            r_end1       <= END_NONE;
            r_run_mask   <= 2'd0;
            r_run_dir0   <= DIR_CW;
            r_run_dir1   <= DIR_CW;
            r_run_period <= MIN_PERIOD;
        end else if (i_fire) begin
            r_running    <= n_running;
            r_step_idx   <= n_step_idx;
            r_rev_cnt    <= n_rev_cnt;
            r_wait_cnt   <= n_wait_cnt;
            r_coils0     <= n_coils0;
            r_coils1     <= n_coils1;
            r_end0       <= n_end0;
            r_end1       <= n_end1;
            r_run_mask   <= n_run_mask;
            r_run_dir0   <= n_run_dir0;
            r_run_dir1   <= n_run_dir1;
            r_run_period <= n_run_period;
        end
    end

    // Result reflects the state after this item
    always_comb begin
        o_res.coils_zero = n_coils0;
        o_res.coils_one  = n_coils1;
        o_res.end_zero   = n_end0;
        o_res.end_one    = n_end1;
        o_res.busy_res   = n_running;
        o_res.done_res   = w_done;
        o_res.bad_mask   = w_bad;
    end

endmodule

// ----- design/dual_stepper_half_step_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stepper_half_step_sequencer
// Half-step sequencer for two four-coil steppers, paced by tick items.
//
//   Channel  Dir  Handshake      Contents
//   i_in     in   valid/ready    action, four active-low limit switches
//   o_out    out  valid/ready    coils, end codes, busy, done, bad mask
//   i_cfg_*  in   write enable   register index and 16-bit write data
//
// One item per cycle sustained while the output is not stalled; each result
// passes through two registers (input register, then result register).
// While a result waits, the input register can still take one item; then
// the input stalls. Reset is synchronous, active low; all coils off, no run.
// A stalled output holds its result and backs up into the input register.
// ----------------------------------------------------------------------------
module dual_stepper_half_step_sequencer import dsseq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dsseq_in_if.sink              i_in,
    dsseq_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;

    logic      w_adv;
    logic      w_fire;
    t_cfg      w_cfg;
    t_out_item w_res;

    assign w_adv      = !r_out_vld || o_out.ready;
    assign w_fire     = r_in_vld && w_adv;
    assign i_in.ready = !r_in_vld || w_adv;

    dsseq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    dsseq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

// ----- design/dsseq_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsseq_chk
// Port-level checks for the dual stepper sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module dsseq_chk import dsseq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // Nothing comes out of reset valid
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A finishing item leaves the coils off and the run idle
    a_done_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.done_res) |->
            (i_out_data.coils_zero == COILS_OFF) &&
            (i_out_data.coils_one == COILS_OFF) && !i_out_data.busy_res)
        else $error("done without coils off");

    // A refused start never starts or finishes a run
    a_bad_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.bad_mask) |->
            !i_out_data.busy_res && !i_out_data.done_res)
        else $error("bad mask with run activity");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind dual_stepper_half_step_sequencer dsseq_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
